// ----- rtl/ssdii_pkg.sv -----
// Shared constants, types and helpers for the shifted squared-difference integral image.
package ssdii_pkg;

  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int MAX_CHANNELS_DEF = 4;
  localparam int MAX_COLUMNS_DEF  = 1024;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam int PORT_CHANNELS = 4;
  localparam int ACC_BITS      = 63;
  localparam int CH_BITS       = 3;
  localparam int ROW_W_BITS    = 11;
  localparam int NOISE_BITS    = 32;
  localparam int OFF_BITS      = NOISE_BITS + CH_BITS;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE     = 2'd2;

  localparam logic [CH_BITS-1:0]    CHANNELS_RST  = 3'd1;
  localparam logic [ROW_W_BITS-1:0] ROW_WIDTH_RST = 11'd1024;
  localparam logic [NOISE_BITS-1:0] NOISE_RST     = 32'd0;

  localparam logic signed [ACC_BITS-1:0] SAT_HI = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] SAT_LO = {1'b1, {(ACC_BITS-1){1'b0}}};

  typedef struct packed {
    logic first_row;
    logic sum_clear;
    logic last;
  } ctl_t;

  // width of one signed distance term
  function automatic int dist_width(input int sample_bits);
    int sum_w;
    sum_w = 2 * sample_bits + 3;
    return ((sum_w > OFF_BITS) ? sum_w : OFF_BITS) + 1;
  endfunction

  function automatic logic signed [ACC_BITS-1:0] sat63(input logic signed [ACC_BITS:0] v);
    if (v[ACC_BITS] != v[ACC_BITS-1]) begin
      return v[ACC_BITS] ? SAT_LO : SAT_HI;
    end
    return v[ACC_BITS-1:0];
  endfunction

endpackage

// ----- rtl/ssdii_front.sv -----
// Front end: configuration registers, request intake, column tracking and distance term.
module ssdii_front #(
  parameter int SAMPLE_BITS  = ssdii_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_CHANNELS = ssdii_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_COLUMNS  = ssdii_pkg::MAX_COLUMNS_DEF,
  localparam int COL_W = $clog2(MAX_COLUMNS),
  localparam int D_W   = ssdii_pkg::dist_width(SAMPLE_BITS)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ssdii_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ssdii_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 frame_start,
  input  logic signed [SAMPLE_BITS-1:0]        ref_ch [ssdii_pkg::PORT_CHANNELS],
  input  logic signed [SAMPLE_BITS-1:0]        shifted_ch [ssdii_pkg::PORT_CHANNELS],
  output logic                                 q_valid,
  input  logic                                 q_ready,
  output logic signed [D_W-1:0]                q_dist,
  output logic [COL_W-1:0]                     q_col,
  output ssdii_pkg::ctl_t                      q_ctl
);

  localparam int SQ_W   = 2 * SAMPLE_BITS + 1;
  localparam int PROD_W = 2 * SAMPLE_BITS + 2;
  localparam int SUM_W  = SQ_W + 2;
  localparam int WCMP_W = (COL_W + 1 > ssdii_pkg::ROW_W_BITS) ? COL_W + 1 : ssdii_pkg::ROW_W_BITS;
  localparam int OFF_W  = ssdii_pkg::OFF_BITS;

  logic [ssdii_pkg::CH_BITS-1:0]    channels_in_use;
  logic [ssdii_pkg::ROW_W_BITS-1:0] row_width;
  logic [ssdii_pkg::NOISE_BITS-1:0] noise_offset;

  logic [ssdii_pkg::CH_BITS-1:0] ch_eff;
  logic [WCMP_W-1:0]             w_ext;
  logic [COL_W-1:0]              w_last;

  logic [COL_W-1:0] column_position;
  logic             in_first_row;
  logic [COL_W-1:0] cp_eff;
  logic             first_eff;
  logic [COL_W-1:0] col;
  logic             last;
  logic             accept;

  logic signed [SAMPLE_BITS:0] diff [MAX_CHANNELS];
  logic signed [PROD_W-1:0]    prod [MAX_CHANNELS];
  logic [SQ_W-1:0]             sq_in [MAX_CHANNELS];
  logic [SQ_W-1:0]             sq_r [MAX_CHANNELS];
  logic [SUM_W-1:0]            sq_sum;
  logic [OFF_W-1:0]            off;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channels_in_use <= ssdii_pkg::CHANNELS_RST;
      row_width       <= ssdii_pkg::ROW_WIDTH_RST;
      noise_offset    <= ssdii_pkg::NOISE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ssdii_pkg::CFG_CHANNELS:  channels_in_use <= cfg_data[ssdii_pkg::CH_BITS-1:0];
        ssdii_pkg::CFG_ROW_WIDTH: row_width <= cfg_data[ssdii_pkg::ROW_W_BITS-1:0];
        ssdii_pkg::CFG_NOISE:     noise_offset <= cfg_data[ssdii_pkg::NOISE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (channels_in_use == '0) begin
      ch_eff = ssdii_pkg::CH_BITS'(1);
    end else if (channels_in_use > ssdii_pkg::CH_BITS'(MAX_CHANNELS)) begin
      ch_eff = ssdii_pkg::CH_BITS'(MAX_CHANNELS);
    end else begin
      ch_eff = channels_in_use;
    end
    w_ext = WCMP_W'(row_width);
    if (w_ext == '0) begin
      w_last = '0;
    end else if (w_ext > WCMP_W'(MAX_COLUMNS)) begin
      w_last = COL_W'(MAX_COLUMNS - 1);
    end else begin
      w_last = COL_W'(w_ext - 1'b1);
    end
  end

  // column of this request, width shrink clamps to the last column
  always_comb begin
    cp_eff    = frame_start ? '0 : column_position;
    first_eff = frame_start | in_first_row;
    col       = (cp_eff > w_last) ? w_last : cp_eff;
    last      = (col == w_last);
  end

  assign in_ready = !q_valid || q_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      diff[k]  = (SAMPLE_BITS + 1)'(ref_ch[k]) - (SAMPLE_BITS + 1)'(shifted_ch[k]);
      prod[k]  = PROD_W'(diff[k]) * PROD_W'(diff[k]);
      sq_in[k] = (ssdii_pkg::CH_BITS'(k) < ch_eff) ? prod[k][SQ_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid         <= 1'b0;
      column_position <= '0;
      in_first_row    <= 1'b1;
    end else begin
      if (accept) begin
        q_valid <= 1'b1;
        if (last) begin
          column_position <= '0;
          in_first_row    <= 1'b0;
        end else begin
          column_position <= COL_W'(col + 1'b1);
          in_first_row    <= first_eff;
        end
      end else if (q_ready) begin
        q_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sq_r            <= sq_in;
      q_col           <= col;
      q_ctl.first_row <= first_eff;
      q_ctl.sum_clear <= (cp_eff == '0);
      q_ctl.last      <= last;
    end
  end

  always_comb begin
    sq_sum = '0;
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      sq_sum = sq_sum + SUM_W'(sq_r[k]);
    end
    off = '0;
    if (ch_eff[0]) off = off + OFF_W'(noise_offset);
    if (ch_eff[1]) off = off + (OFF_W'(noise_offset) << 1);
    if (ch_eff[2]) off = off + (OFF_W'(noise_offset) << 2);
    q_dist = D_W'(sq_sum) - D_W'(off);
  end

`ifndef ASSERT_OFF
  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> column_position == '0 && !in_first_row)
    else $error("row end did not restart column");
  a_col_steps: assert property (@(posedge clk) disable iff (rst)
    accept && !last |=> column_position == COL_W'($past(col) + 1'b1))
    else $error("column did not advance by one");
`endif

endmodule

// ----- rtl/ssdii_queue.sv -----
// Small request queue between front and back.
module ssdii_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ssdii_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- rtl/ssdii_back.sv -----
// Back end: running row sum, line store of the row above and output register.
module ssdii_back #(
  parameter int SAMPLE_BITS = ssdii_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_COLUMNS = ssdii_pkg::MAX_COLUMNS_DEF,
  localparam int COL_W = $clog2(MAX_COLUMNS),
  localparam int D_W   = ssdii_pkg::dist_width(SAMPLE_BITS)
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       q_valid,
  output logic                                       q_ready,
  input  logic signed [D_W-1:0]                      q_dist,
  input  logic [COL_W-1:0]                           q_col,
  input  ssdii_pkg::ctl_t                            q_ctl,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic signed [ssdii_pkg::ACC_BITS-1:0]      integral_value,
  output logic                                       row_done
);

  localparam int A_W = ssdii_pkg::ACC_BITS;

  logic                  b1_valid;
  logic signed [D_W-1:0] b1_dist;
  logic [COL_W-1:0]      b1_col;
  ssdii_pkg::ctl_t       b1_ctl;

  logic signed [A_W-1:0] run_sum;
  logic signed [A_W-1:0] base;
  logic signed [A_W-1:0] new_sum;

  logic                  b2_valid;
  logic signed [A_W-1:0] s_sum;
  logic [COL_W-1:0]      b2_col;
  logic                  b2_first;
  logic                  b2_last;
  logic                  b2_fwd;
  logic signed [A_W-1:0] above_rd;
  logic signed [A_W-1:0] above;
  logic signed [A_W-1:0] result;

  logic signed [A_W-1:0] line_mem [MAX_COLUMNS];

  logic b3_free;
  logic b2_adv;
  logic b2_free;
  logic b1_adv;

  assign b3_free = !out_valid || out_ready;
  assign b2_adv  = b2_valid && b3_free;
  assign b2_free = !b2_valid || b2_adv;
  assign b1_adv  = b1_valid && b2_free;
  assign q_ready = !b1_valid || b1_adv;

  always_comb begin
    base    = b1_ctl.sum_clear ? '0 : run_sum;
    new_sum = ssdii_pkg::sat63((A_W + 1)'(base) + (A_W + 1)'(b1_dist));
  end

  // a pending write to the same column sits in the output register
  always_comb begin
    if (b2_first) begin
      above = '0;
    end else if (b2_fwd) begin
      above = integral_value;
    end else begin
      above = above_rd;
    end
    result = ssdii_pkg::sat63((A_W + 1)'(s_sum) + (A_W + 1)'(above));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
      out_valid <= 1'b0;
      run_sum   <= '0;
    end else begin
      if (q_ready) begin
        b1_valid <= q_valid;
      end
      if (b2_free) begin
        b2_valid <= b1_valid;
      end
      if (b3_free) begin
        out_valid <= b2_valid;
      end
      if (b1_adv) begin
        run_sum <= new_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready) begin
      b1_dist <= q_dist;
      b1_col  <= q_col;
      b1_ctl  <= q_ctl;
    end
    if (b1_adv) begin
      s_sum    <= new_sum;
      b2_col   <= b1_col;
      b2_first <= b1_ctl.first_row;
      b2_last  <= b1_ctl.last;
      b2_fwd   <= b2_valid && (b2_col == b1_col);
    end
    if (b2_adv) begin
      integral_value <= result;
      row_done       <= b2_last;
    end
  end

  always_ff @(posedge clk) begin
    if (b2_adv) begin
      line_mem[b2_col] <= result;
    end
    if (b1_adv) begin
      above_rd <= line_mem[b1_col];
    end
  end

`ifndef ASSERT_OFF
  a_b2_loaded: assert property (@(posedge clk) disable iff (rst)
    b1_adv |=> b2_valid)
    else $error("stage two lost a request");
  a_b2_holds: assert property (@(posedge clk) disable iff (rst)
    b2_valid && !b2_adv |=> b2_valid && $stable(b2_col) && $stable(s_sum))
    else $error("stalled stage two changed");
`endif

endmodule

// ----- rtl/shifted_sq_diff_integral_image_top.sv -----
// Top level of the shifted squared-difference integral image block.
// One pixel pair is accepted per clock cycle, sustained without output stalls, and passes the
// front register, queue, back stages one and two and output register. The rate is set by the
// running row sum, which adds one distance term per cycle, and by the line store, which reads
// the entry above and writes the new integral once each per cycle; a pending write to the same
// column is forwarded. A four-entry queue between the front end (distance term, column
// tracking) and the back end (sums, line store) lets either side stall independently. The line
// store needs no clearing after reset: the first row of each region reads zero from above.
module shifted_sq_diff_integral_image_top #(
  parameter int SAMPLE_BITS  = ssdii_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_CHANNELS = ssdii_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_COLUMNS  = ssdii_pkg::MAX_COLUMNS_DEF,
  parameter int QUEUE_DEPTH  = ssdii_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ssdii_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ssdii_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   frame_start,
  input  logic signed [SAMPLE_BITS-1:0]          ref_ch0,
  input  logic signed [SAMPLE_BITS-1:0]          ref_ch1,
  input  logic signed [SAMPLE_BITS-1:0]          ref_ch2,
  input  logic signed [SAMPLE_BITS-1:0]          ref_ch3,
  input  logic signed [SAMPLE_BITS-1:0]          shifted_ch0,
  input  logic signed [SAMPLE_BITS-1:0]          shifted_ch1,
  input  logic signed [SAMPLE_BITS-1:0]          shifted_ch2,
  input  logic signed [SAMPLE_BITS-1:0]          shifted_ch3,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [ssdii_pkg::ACC_BITS-1:0]  integral_value,
  output logic                                   row_done
);

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int D_W   = ssdii_pkg::dist_width(SAMPLE_BITS);
  localparam int CTL_W = $bits(ssdii_pkg::ctl_t);
  localparam int Q_W   = D_W + COL_W + CTL_W;

  logic signed [SAMPLE_BITS-1:0] ref_s [ssdii_pkg::PORT_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] shf_s [ssdii_pkg::PORT_CHANNELS];

  logic                  fq_valid;
  logic                  fq_ready;
  logic signed [D_W-1:0] fq_dist;
  logic [COL_W-1:0]      fq_col;
  ssdii_pkg::ctl_t       fq_ctl;

  logic                  qb_valid;
  logic                  qb_ready;
  logic [Q_W-1:0]        qb_data;
  logic signed [D_W-1:0] qb_dist;
  logic [COL_W-1:0]      qb_col;
  ssdii_pkg::ctl_t       qb_ctl;

  assign ref_s[0] = ref_ch0;
  assign ref_s[1] = ref_ch1;
  assign ref_s[2] = ref_ch2;
  assign ref_s[3] = ref_ch3;
  assign shf_s[0] = shifted_ch0;
  assign shf_s[1] = shifted_ch1;
  assign shf_s[2] = shifted_ch2;
  assign shf_s[3] = shifted_ch3;

  ssdii_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_CHANNELS(MAX_CHANNELS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .frame_start(frame_start),
    .ref_ch     (ref_s),
    .shifted_ch (shf_s),
    .q_valid    (fq_valid),
    .q_ready    (fq_ready),
    .q_dist     (fq_dist),
    .q_col      (fq_col),
    .q_ctl      (fq_ctl)
  );

  ssdii_queue #(
    .WIDTH(Q_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(fq_valid),
    .push_ready(fq_ready),
    .push_data ({fq_dist, fq_col, fq_ctl}),
    .pop_valid (qb_valid),
    .pop_ready (qb_ready),
    .pop_data  (qb_data)
  );

  assign qb_dist = qb_data[Q_W-1:COL_W+CTL_W];
  assign qb_col  = qb_data[COL_W+CTL_W-1:CTL_W];
  assign qb_ctl  = qb_data[CTL_W-1:0];

  ssdii_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (qb_valid),
    .q_ready       (qb_ready),
    .q_dist        (qb_dist),
    .q_col         (qb_col),
    .q_ctl         (qb_ctl),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .integral_value(integral_value),
    .row_done      (row_done)
  );

endmodule
